[src/dwpd_pkg.sv]
package dwpd_pkg;

  localparam int unsigned POS_FRAC_BITS_DEF = 8;

  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 25;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int unsigned APB_AW = 5;

  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_DERIV_GAIN    = 3'd1,
    REG_CM_PER_COUNT  = 3'd2,
    REG_ARRIVE_THRESH = 3'd3,
    REG_SPEED_MIN     = 3'd4,
    REG_SPEED_MAX     = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic        [15:0] prop_gain;
    logic        [15:0] deriv_gain;
    logic        [23:0] cm_per_count;
    logic        [15:0] arrive_threshold;
    logic signed [15:0] speed_min;
    logic signed [15:0] speed_max;
  } cfg_t;

endpackage

[src/dwpd_mul.sv]
module dwpd_mul import dwpd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0] p_o
);

  logic signed [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

[src/dwpd_regs.sv]
module dwpd_regs import dwpd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain        <= 16'd256;
      cfg_q.deriv_gain       <= 16'd0;
      cfg_q.cm_per_count     <= 24'd16384;
      cfg_q.arrive_threshold <= 16'd128;
      cfg_q.speed_min        <= -16'sd300;
      cfg_q.speed_max        <= 16'sd300;
    end else if (wr) begin
      case (idx)
        REG_PROP_GAIN:     cfg_q.prop_gain        <= pwdata[15:0];
        REG_DERIV_GAIN:    cfg_q.deriv_gain       <= pwdata[15:0];
        REG_CM_PER_COUNT:  cfg_q.cm_per_count     <= pwdata[23:0];
        REG_ARRIVE_THRESH: cfg_q.arrive_threshold <= pwdata[15:0];
        REG_SPEED_MIN:     cfg_q.speed_min        <= $signed(pwdata[15:0]);
        REG_SPEED_MAX:     cfg_q.speed_max        <= $signed(pwdata[15:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PROP_GAIN:     prdata = {16'd0, cfg_q.prop_gain};
      REG_DERIV_GAIN:    prdata = {16'd0, cfg_q.deriv_gain};
      REG_CM_PER_COUNT:  prdata = {8'd0, cfg_q.cm_per_count};
      REG_ARRIVE_THRESH: prdata = {16'd0, cfg_q.arrive_threshold};
      REG_SPEED_MIN:     prdata = 32'(cfg_q.speed_min);
      REG_SPEED_MAX:     prdata = 32'(cfg_q.speed_max);
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[src/dual_wheel_pd_position_loop.sv]
// A control tick scales both encoder counts, updates the errors and checks
// arrival, then forms the PD terms unless both wheels have arrived; a reset
// command goes straight to the output. One item is in work at a time and the
// next can be taken in the cycle after the result is loaded. All products go
// through the shared multiplier: one count scaling and two PD terms per wheel.
// Reset (rst_ni, async, active low) restores register defaults and clears
// positions, stored errors and the output valid.
module dual_wheel_pd_position_loop import dwpd_pkg::*; #(
  parameter int unsigned POSITION_FRAC_BITS = POS_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [15:0] enc_left, [31:16] enc_right, [63:32] goal_pos
  input  logic [63:0]       s_axis_tdata,
  // [0] command
  input  logic [0:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [15:0] speed_left, [31:16] speed_right, [32] arrived, [39:33] zero
  output logic [39:0]       m_axis_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned SW     = MUL_P_W + 1;
  localparam int unsigned INC_SH = 20 - POSITION_FRAC_BITS;
  localparam int unsigned PD_SH  = 8 + POSITION_FRAC_BITS;
  localparam logic signed [SW-1:0] INC_RND = SW'(1) << (INC_SH - 1);
  localparam logic signed [SW-1:0] MAX32   = SW'(64'sh7FFF_FFFF);
  localparam logic signed [SW-1:0] MIN32   = -MAX32 - SW'(1);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b0_0000_0001,
    ST_MCNT = 9'b0_0000_0010,
    ST_POS  = 9'b0_0000_0100,
    ST_ERR  = 9'b0_0000_1000,
    ST_CHK  = 9'b0_0001_0000,
    ST_MP   = 9'b0_0010_0000,
    ST_MD   = 9'b0_0100_0000,
    ST_SUM  = 9'b0_1000_0000,
    ST_OUT  = 9'b1_0000_0000
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] x);
    logic signed [31:0] r;
    if (x > MAX32) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < MIN32) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  cfg_t cfg;

  dwpd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e state_q, state_d;
  logic   side_q;

  logic signed [15:0] cnt_q [2];
  logic signed [31:0] target_q;
  logic signed [31:0] pos_q  [2];
  logic signed [31:0] prev_q [2];
  logic signed [31:0] err_q  [2];
  logic signed [MUL_P_W-1:0] acc_q;
  logic signed [15:0] res_q  [2];
  logic               res_arr_q;
  logic               out_valid_q;
  logic [39:0]        out_data_q;

  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  dwpd_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  logic signed [32:0] diff;
  logic signed [SW-1:0] inc, pos_sum, pd_sum, pd_sh, clamp_hi, clamp_lo;
  logic signed [31:0] err_l_d, err_r_d;
  logic [32:0] mag_l, mag_r;
  logic        near;
  logic        in_acc, out_free;

  assign diff = 33'(err_q[side_q]) - 33'(prev_q[side_q]);

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      ST_MCNT: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(cnt_q[side_q]);
        mul_b  = $signed({1'b0, cfg.cm_per_count});
      end
      ST_MP: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(err_q[side_q]);
        mul_b  = $signed({{(MUL_B_W - 16){1'b0}}, cfg.prop_gain});
      end
      ST_MD: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(diff);
        mul_b  = $signed({{(MUL_B_W - 16){1'b0}}, cfg.deriv_gain});
      end
      default: ;
    endcase
  end

  assign inc     = (SW'(mul_p) + INC_RND) >>> INC_SH;
  assign pos_sum = SW'(pos_q[side_q]) + inc;

  assign err_l_d = sat32(SW'(target_q) - SW'(pos_q[0]));
  assign err_r_d = sat32(SW'(target_q) - SW'(pos_q[1]));

  assign mag_l = err_q[0][31] ? 33'(-33'(err_q[0])) : {1'b0, err_q[0]};
  assign mag_r = err_q[1][31] ? 33'(-33'(err_q[1])) : {1'b0, err_q[1]};
  assign near  = (mag_l < {17'd0, cfg.arrive_threshold}) &&
                 (mag_r < {17'd0, cfg.arrive_threshold});

  assign pd_sum   = SW'(acc_q) + SW'(mul_p);
  assign pd_sh    = pd_sum >>> PD_SH;
  assign clamp_hi = (pd_sh > SW'(cfg.speed_max)) ? SW'(cfg.speed_max) : pd_sh;
  assign clamp_lo = (clamp_hi < SW'(cfg.speed_min)) ? SW'(cfg.speed_min) : clamp_hi;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = s_axis_tuser[0] ? ST_OUT : ST_MCNT;
      ST_MCNT: state_d = ST_POS;
      ST_POS:  state_d = side_q ? ST_ERR : ST_MCNT;
      ST_ERR:  state_d = ST_CHK;
      ST_CHK:  state_d = near ? ST_OUT : ST_MP;
      ST_MP:   state_d = ST_MD;
      ST_MD:   state_d = ST_SUM;
      ST_SUM:  state_d = side_q ? ST_OUT : ST_MP;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      side_q      <= 1'b0;
      pos_q[0]    <= '0;
      pos_q[1]    <= '0;
      prev_q[0]   <= '0;
      prev_q[1]   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          side_q <= 1'b0;
          if (in_acc && s_axis_tuser[0]) begin
            pos_q[0]  <= '0;
            pos_q[1]  <= '0;
            prev_q[0] <= '0;
            prev_q[1] <= '0;
          end
        end
        ST_POS: begin
          pos_q[side_q] <= sat32(pos_sum);
          side_q        <= ~side_q;
        end
        ST_CHK: begin
          if (near) begin
            prev_q[0] <= '0;
            prev_q[1] <= '0;
          end
        end
        ST_SUM: begin
          prev_q[side_q] <= err_q[side_q];
          side_q         <= ~side_q;
        end
        default: ;
      endcase
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_q[0]  <= $signed(s_axis_tdata[15:0]);
          cnt_q[1]  <= $signed(s_axis_tdata[31:16]);
          target_q  <= $signed(s_axis_tdata[63:32]);
          res_q[0]  <= '0;
          res_q[1]  <= '0;
          res_arr_q <= 1'b0;
        end
      end
      ST_ERR: begin
        err_q[0] <= err_l_d;
        err_q[1] <= err_r_d;
      end
      ST_CHK:  res_arr_q <= near;
      ST_MD:   acc_q <= mul_p;
      ST_SUM:  res_q[side_q] <= clamp_lo[15:0];
      ST_OUT: begin
        if (out_free) begin
          out_data_q <= {7'd0, res_arr_q, res_q[1], res_q[0]};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[dv/tb_dual_wheel_pd_position_loop.sv]
`timescale 1ns / 1ps

module tb_dual_wheel_pd_position_loop;
  import dwpd_pkg::*;

  localparam int unsigned POS_F        = POS_FRAC_BITS_DEF;
  localparam int unsigned INC_SHIFT    = 20 - POS_F;
  localparam int unsigned REG_UNUSED   = 6;
  localparam logic        CMD_TICK     = 1'b0;
  localparam logic        CMD_RESET    = 1'b1;
  localparam int          WD_LIMIT     = 4000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          SETTLE_CYCLES = 16;
  localparam longint      I32_MAX      = 64'sd2147483647;
  localparam longint      I32_MIN      = -64'sd2147483648;

  // input item: enc_left lowest
  typedef struct packed {
    logic        [31:0] target;
    logic signed [15:0] enc_right;
    logic signed [15:0] enc_left;
  } tick_item_t;

  // result item: speed_left lowest
  typedef struct packed {
    logic        [6:0]  pad;
    logic               arrived;
    logic signed [15:0] speed_right;
    logic signed [15:0] speed_left;
  } speed_result_t;

  class pd_scoreboard;
    logic        [15:0] kp, kd, thr;
    logic        [23:0] cpc;
    logic signed [15:0] smin, smax;
    int pos_l, pos_r, perr_l, perr_r;
    speed_result_t speed_q[$];
    int errors, n_in, n_out, n_arrived, n_resets;

    function new();
      kp = 16'd256; kd = 16'd0; cpc = 24'd16384; thr = 16'd128;
      smin = -16'sd300; smax = 16'sd300;
      pos_l = 0; pos_r = 0; perr_l = 0; perr_r = 0;
      errors = 0; n_in = 0; n_out = 0; n_arrived = 0; n_resets = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [31:0] v);
      case (idx)
        REG_PROP_GAIN:     kp   = v[15:0];
        REG_DERIV_GAIN:    kd   = v[15:0];
        REG_CM_PER_COUNT:  cpc  = v[23:0];
        REG_ARRIVE_THRESH: thr  = v[15:0];
        REG_SPEED_MIN:     smin = v[15:0];
        REG_SPEED_MAX:     smax = v[15:0];
        default: ;
      endcase
    endfunction

    function int sat32(longint x);
      if (x > I32_MAX) return int'(I32_MAX);
      if (x < I32_MIN) return int'(I32_MIN);
      return int'(x);
    endfunction

    function int advance(int pos, logic signed [15:0] cnt);
      longint prod, inc;
      prod = longint'(cnt) * longint'(cpc);
      inc  = (prod + (longint'(1) << (INC_SHIFT - 1))) >>> INC_SHIFT;
      return sat32(longint'(pos) + inc);
    endfunction

    function logic signed [15:0] pd_speed(int err, inout int prev);
      longint diff, acc, spd;
      diff = longint'(err) - longint'(prev);
      acc  = longint'(kp) * longint'(err) + longint'(kd) * diff;
      spd  = acc >>> (8 + POS_F);
      prev = err;
      if (spd > longint'(smax)) spd = longint'(smax);
      if (spd < longint'(smin)) spd = longint'(smin);
      return spd[15:0];
    endfunction

    function void note_input(logic cmd, tick_item_t it);
      speed_result_t r;
      longint tgt, el, er, ml, mr;
      r = '0;
      n_in++;
      if (cmd == CMD_RESET) begin
        pos_l = 0; pos_r = 0; perr_l = 0; perr_r = 0;
        n_resets++;
      end else begin
        tgt   = longint'(signed'(it.target));
        pos_l = advance(pos_l, it.enc_left);
        pos_r = advance(pos_r, it.enc_right);
        el = sat32(tgt - longint'(pos_l));
        er = sat32(tgt - longint'(pos_r));
        ml = (el < 0) ? -el : el;
        mr = (er < 0) ? -er : er;
        if (ml < longint'(thr) && mr < longint'(thr)) begin
          r.arrived = 1'b1;
          perr_l = 0; perr_r = 0;
          n_arrived++;
        end else begin
          r.speed_left  = pd_speed(int'(el), perr_l);
          r.speed_right = pd_speed(int'(er), perr_r);
        end
      end
      speed_q.push_back(r);
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("ERROR: %s", what);
    endfunction

    function void check(logic [39:0] data);
      speed_result_t got, exp_r;
      got = speed_result_t'(data);
      n_out++;
      if (speed_q.size() == 0) begin
        flag($sformatf("result %0d with none pending: %h", n_out, data));
        return;
      end
      exp_r = speed_q.pop_front();
      if (got.speed_left !== exp_r.speed_left || got.speed_right !== exp_r.speed_right ||
          got.arrived !== exp_r.arrived || got.pad !== exp_r.pad)
        flag($sformatf({"result %0d: speed_left exp %0d got %0d, speed_right exp %0d got %0d,",
                        " arrived exp %0b got %0b, pad exp %h got %h"},
                       n_out, exp_r.speed_left, got.speed_left, exp_r.speed_right,
                       got.speed_right, exp_r.arrived, got.arrived, exp_r.pad, got.pad));
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata  = '0;
  logic [0:0]        s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [39:0]       m_axis_tdata;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [APB_AW-1:0] paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;

  pd_scoreboard sb = new();
  int snd_idle  = 0;
  int rcv_stall = 0;
  bit hold_req  = 1'b0;
  int n_settings = 0;
  int idle_cycles = 0;

  dual_wheel_pd_position_loop i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall);
      end
    end
  end

  initial begin
    while (idle_cycles < WD_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no item moved for %0d cycles", WD_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic tick_item_t mk_item(int cl, int cr, logic [31:0] tgt);
    tick_item_t it;
    it.enc_left  = cl[15:0];
    it.enc_right = cr[15:0];
    it.target    = tgt;
    return it;
  endfunction

  task automatic send_item(logic cmd, tick_item_t it);
    while ($urandom_range(0, 99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(cmd, it);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.speed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(int unsigned idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx * 4);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic apply_config(int kp, int kd, int cpc, int thr, int smin, int smax);
    reg_write(REG_PROP_GAIN, 32'(kp));
    reg_write(REG_DERIV_GAIN, 32'(kd));
    reg_write(REG_CM_PER_COUNT, 32'(cpc));
    reg_write(REG_ARRIVE_THRESH, 32'(thr));
    reg_write(REG_SPEED_MIN, 32'(smin));
    reg_write(REG_SPEED_MAX, 32'(smax));
    n_settings++;
  endtask

  // mostly runs after a reset command: approach a target near the position,
  // run away at full scale, or chase a fixed target; some pure noise
  task automatic run_random(int n_items);
    int sent, len, kind, cl, cr, off, thr, k;
    logic [31:0] fixed_tgt, tgt;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 10) begin
        send_item(1'($urandom_range(0, 1)), {$urandom, $urandom});
        sent++;
      end else begin
        send_item(CMD_RESET, {$urandom, $urandom});
        sent++;
        len  = $urandom_range(4, 40);
        kind = $urandom_range(0, 2);
        fixed_tgt = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 20000));
        for (k = 0; k < len && sent < n_items; k++) begin
          case (kind)
            0: begin
              thr = int'(sb.thr);
              cl  = int'($urandom_range(0, 400)) - 200;
              cr  = ($urandom_range(0, 3) == 0) ? cl + int'($urandom_range(0, 8)) - 4 : cl;
              off = int'($urandom_range(0, 2 * thr + 4)) - (thr + 2);
              tgt = ($urandom_range(0, 9) == 0) ? $urandom
                                                : 32'(sb.advance(sb.pos_l, cl[15:0]) + off);
            end
            1: begin
              cl  = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 15))
                                         : -32768 + int'($urandom_range(0, 15));
              cr  = ($urandom_range(0, 1)) ? cl : -cl - 1;
              tgt = $urandom_range(0, 1) ? 32'h7fffffff
                                         : ($urandom_range(0, 1) ? 32'h80000000 : fixed_tgt);
            end
            default: begin
              cl  = int'($urandom);
              cr  = $urandom_range(0, 1) ? cl : int'($urandom);
              tgt = fixed_tgt;
            end
          endcase
          send_item(CMD_TICK, mk_item(cl, cr, tgt));
          sent++;
        end
      end
    end
  endtask

  task automatic directed();
    send_item(CMD_TICK, mk_item(0, 0, 32'd0));
    send_item(CMD_TICK, mk_item(1, 1, 32'd0));
    send_item(CMD_TICK, mk_item(0, 0, 32'd300));
    send_item(CMD_TICK, mk_item(0, 0, 32'd300));
    send_item(CMD_TICK, mk_item(32767, -32768, 32'h7fffffff));
    send_item(CMD_TICK, mk_item(-32768, 32767, 32'h80000000));
    send_item(CMD_RESET, mk_item(-1, -1, 32'hffffffff));
    send_item(CMD_TICK, mk_item(0, 0, 32'hffffff80));
    settle();
    apply_config(65535, 65535, 24'hffffff, 0, -32768, 32767);
    send_item(CMD_TICK, mk_item(32767, 32767, 32'h80000000));
    send_item(CMD_TICK, mk_item(-32768, -32768, 32'h7fffffff));
    send_item(CMD_TICK, mk_item(-32768, 32767, 32'h7fffffff));
    send_item(CMD_RESET, mk_item(0, 0, 32'd0));
    send_item(CMD_TICK, mk_item(0, 0, 32'd0));
    settle();
    // crossed limits, and cm_per_count giving exact rounding ties
    apply_config(300, 200, 2048, 4, 100, -100);
    send_item(CMD_TICK, mk_item(1, -1, 32'd0));
    send_item(CMD_TICK, mk_item(-1, 1, 32'd2));
    send_item(CMD_TICK, mk_item(3, -3, 32'd1000));
    send_item(CMD_TICK, mk_item(0, 0, -32'sd1000));
    settle();
    reg_write(REG_UNUSED, 32'hdeadbeef);
    send_item(CMD_TICK, mk_item(0, 0, 32'd5000));
    send_item(CMD_RESET, mk_item(5, 5, 32'd5));
    send_item(CMD_TICK, mk_item(0, 0, 32'd1));
  endtask

  initial begin
    int phase;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    for (phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0: apply_config(256, 0, 16384, 128, -300, 300);
        1: apply_config(65535, 65535, 24'hffffff, 0, -32768, 32767);
        2: apply_config(0, 0, 0, 65535, 0, 0);
        3: apply_config($urandom_range(0, 4095), $urandom_range(0, 65535),
                        $urandom_range(0, 1 << 20), $urandom_range(0, 512), 500, -500);
        default: apply_config($urandom_range(0, 4095), $urandom_range(0, 8191),
                              $urandom_range(0, 1 << 20), $urandom_range(0, 2048),
                              -int'($urandom_range(1, 32768)), $urandom_range(0, 32767));
      endcase
      if (phase == 4) reg_write(REG_UNUSED + 1, $urandom);
      case (phase % 4)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 76; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 76; end
        default: begin snd_idle = 9; rcv_stall = 9; end
      endcase
      if (phase % 4 == 0) hold_req = 1'b1;
      run_random(250);
    end
    settle();
    $display("Covered %0d items, %0d results, %0d arrivals, %0d reset commands,",
             sb.n_in, sb.n_out, sb.n_arrived, sb.n_resets);
    $display("over %0d register settings incl. extremes and crossed limits; %0d mismatches",
             n_settings, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
